// ===== rtl/minv_pkg.sv =====
package minv_pkg;

    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int LANES          = 9;

    typedef logic [3:0] idx_t;

    // cofactor k (column major) = +/-(m[P]*m[Q] - m[R]*m[S])
    localparam idx_t COF_P [LANES] = '{4'd4, 4'd1, 4'd1, 4'd3, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0};
    localparam idx_t COF_Q [LANES] = '{4'd8, 4'd8, 4'd5, 4'd8, 4'd8, 4'd5, 4'd7, 4'd7, 4'd4};
    localparam idx_t COF_R [LANES] = '{4'd5, 4'd2, 4'd2, 4'd6, 4'd6, 4'd2, 4'd6, 4'd1, 4'd1};
    localparam idx_t COF_S [LANES] = '{4'd7, 4'd7, 4'd4, 4'd5, 4'd2, 4'd3, 4'd4, 4'd6, 4'd3};
    localparam logic [LANES-1:0] COF_NEG = 9'b010101010;

    // column-major source index of the transposed element
    localparam idx_t TRANS_SRC [LANES] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    // first-row elements used for the determinant
    localparam idx_t DET_COL [3] = '{4'd0, 4'd3, 4'd6};

    typedef struct packed {
        logic             singular;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] ovf;
    } minv_flags_t;

endpackage

// ===== rtl/matrix_inverse_3x3_top.sv =====
// 3x3 matrix inverse by adjugate over determinant, signed fixed point (Q16.16 by default),
// elements column major. One matrix is taken per cycle while s_tready is high; s_tready drops
// only while a result waits at the output with m_tready low and another is behind it. The radix-2
// divider resolves one quotient bit per stage for all nine elements in parallel, behind six stages
// of cofactor and determinant arithmetic and one range-check stage. Quotients round toward zero and
// saturate. A zero determinant returns singular (m_tuser) with all elements zero. s_tuser selects
// the inverse (0) or its transpose (1). The block holds no state between matrices.
module matrix_inverse_3x3_top #(
    parameter int ELEM_WIDTH  = minv_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS   = minv_pkg::FRAC_BITS_DEF,
    localparam int TDATA_W    = ((minv_pkg::LANES * ELEM_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // in_r0c0, in_r1c0, in_r2c0, in_r0c1 .. in_r2c2
    input  logic [0:0]         s_tuser,   // mode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // out_r0c0, out_r1c0, out_r2c0, out_r0c1 .. out_r2c2
    output logic [0:0]         m_tuser    // singular
);
    import minv_pkg::*;

    localparam int E  = ELEM_WIDTH;
    localparam int PW = 2 * E;
    localparam int CW = 2 * E + 1;
    localparam int LW = 2 * E + 1;
    localparam int DW = 3 * E + 3;
    localparam int NW = CW + 2 * FRAC_BITS;
    localparam int WW = (NW > DW + E) ? NW : DW + E;

    logic ce;
    logic out_load;
    logic [6:0] vld_reg;

    logic signed [E-1:0]  elem [LANES];

    logic signed [PW-1:0] s1_pa_reg [LANES];
    logic signed [PW-1:0] s1_pb_reg [LANES];
    logic signed [E-1:0]  s1_col_reg [3];
    logic                 s1_mode_reg;

    logic signed [CW-1:0] s2_cof_reg [LANES];
    logic signed [E-1:0]  s2_col_reg [3];
    logic                 s2_mode_reg;

    logic signed [LW-1:0] s3_plo_reg [3];
    logic signed [LW-1:0] s3_phi_reg [3];
    logic signed [CW-1:0] s3_cof_reg [LANES];
    logic                 s3_mode_reg;

    logic signed [DW-1:0] s4_prod_reg [3];
    logic signed [CW-1:0] s4_cof_reg [LANES];
    logic                 s4_mode_reg;

    logic signed [DW-1:0] s5_det_reg;
    logic signed [CW-1:0] s5_cof_reg [LANES];
    logic                 s5_mode_reg;

    logic                 s6_dneg;
    logic [DW-1:0]        s6_dmag;
    logic signed [CW-1:0] s6_csel [LANES];
    logic [CW-1:0]        s6_cabs [LANES];
    logic [LANES-1:0]     s6_neg;
    logic [DW-1:0]        s6_dmag_reg;
    logic [LANES-1:0]     s6_neg_reg;
    logic [LANES-1:0][WW-1:0] s6_num_reg;

    logic [DW-1:0]            s7_dmag_reg;
    minv_flags_t              s7_flags_reg;
    logic [LANES-1:0][WW-1:0] s7_rem_reg;

    logic [E:0]                       div_valid;
    logic [DW-1:0]                    div_dmag  [E+1];
    minv_flags_t                      div_flags [E+1];
    logic [LANES-1:0][WW-1:0]         div_rem   [E+1];
    logic [LANES-1:0][E-1:0]          div_quo   [E+1];

    logic [E-1:0]         fin_lim [LANES];
    logic [E-1:0]         fin_mag [LANES];
    logic [TDATA_W-1:0]   fin_data;

    logic                 out_valid_reg;
    logic [TDATA_W-1:0]   out_data_reg;
    logic                 out_sing_reg;

    assign out_load = !out_valid_reg || m_tready;
    assign ce       = out_load || !div_valid[E];
    assign s_tready = ce;

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            elem[k] = s_tdata[k*E +: E];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[5:0], s_tvalid};
        end
    end

    // products, cofactors, determinant
    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < LANES; k++) begin
                s1_pa_reg[k] <= elem[COF_P[k]] * elem[COF_Q[k]];
                s1_pb_reg[k] <= elem[COF_R[k]] * elem[COF_S[k]];
            end
            for (int j = 0; j < 3; j++) begin
                s1_col_reg[j] <= elem[DET_COL[j]];
            end
            s1_mode_reg <= s_tuser[0];

            for (int k = 0; k < LANES; k++) begin
                s2_cof_reg[k] <= COF_NEG[k] ? CW'(s1_pb_reg[k]) - CW'(s1_pa_reg[k])
                                            : CW'(s1_pa_reg[k]) - CW'(s1_pb_reg[k]);
            end
            s2_col_reg  <= s1_col_reg;
            s2_mode_reg <= s1_mode_reg;

            for (int j = 0; j < 3; j++) begin
                s3_plo_reg[j] <= s2_col_reg[j] * $signed({1'b0, s2_cof_reg[j][E-1:0]});
                s3_phi_reg[j] <= s2_col_reg[j] * $signed(s2_cof_reg[j][CW-1:E]);
            end
            s3_cof_reg  <= s2_cof_reg;
            s3_mode_reg <= s2_mode_reg;

            for (int j = 0; j < 3; j++) begin
                s4_prod_reg[j] <= (DW'(s3_phi_reg[j]) <<< E) + DW'(s3_plo_reg[j]);
            end
            s4_cof_reg  <= s3_cof_reg;
            s4_mode_reg <= s3_mode_reg;

            s5_det_reg  <= s4_prod_reg[0] + s4_prod_reg[1] + s4_prod_reg[2];
            s5_cof_reg  <= s4_cof_reg;
            s5_mode_reg <= s4_mode_reg;
        end
    end

    // magnitudes and signs, element order per mode
    always_comb begin
        s6_dneg = s5_det_reg[DW-1];
        s6_dmag = s6_dneg ? DW'(-s5_det_reg) : DW'(s5_det_reg);
        for (int k = 0; k < LANES; k++) begin
            s6_csel[k] = s5_mode_reg ? s5_cof_reg[TRANS_SRC[k]] : s5_cof_reg[k];
            s6_cabs[k] = s6_csel[k][CW-1] ? CW'(-s6_csel[k]) : CW'(s6_csel[k]);
            s6_neg[k]  = s6_csel[k][CW-1] ^ s6_dneg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s6_dmag_reg <= s6_dmag;
            s6_neg_reg  <= s6_neg;
            for (int k = 0; k < LANES; k++) begin
                s6_num_reg[k] <= WW'(s6_cabs[k]) << (2 * FRAC_BITS);
            end

            s7_dmag_reg           <= s6_dmag_reg;
            s7_flags_reg.singular <= (s6_dmag_reg == '0);
            s7_flags_reg.neg      <= s6_neg_reg;
            for (int k = 0; k < LANES; k++) begin
                s7_flags_reg.ovf[k] <= s6_num_reg[k] >= (WW'(s6_dmag_reg) << E);
            end
            s7_rem_reg <= s6_num_reg;
        end
    end

    assign div_valid[0] = vld_reg[6];
    assign div_dmag[0]  = s7_dmag_reg;
    assign div_flags[0] = s7_flags_reg;
    assign div_rem[0]   = s7_rem_reg;
    assign div_quo[0]   = '0;

    for (genvar s = 0; s < E; s++) begin : g_div
        minv_div_stage #(
            .ELEM_WIDTH (E),
            .DMAG_W     (DW),
            .REM_W      (WW),
            .BIT_POS    (E - 1 - s)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (div_valid[s]),
            .dmag_in   (div_dmag[s]),
            .flags_in  (div_flags[s]),
            .rem_in    (div_rem[s]),
            .quo_in    (div_quo[s]),
            .out_valid (div_valid[s+1]),
            .dmag_out  (div_dmag[s+1]),
            .flags_out (div_flags[s+1]),
            .rem_out   (div_rem[s+1]),
            .quo_out   (div_quo[s+1])
        );
    end

    // saturate, apply sign, force zero when singular
    always_comb begin
        fin_data = '0;
        for (int k = 0; k < LANES; k++) begin
            fin_lim[k] = div_flags[E].neg[k] ? {1'b1, {(E-1){1'b0}}} : {1'b0, {(E-1){1'b1}}};
            fin_mag[k] = (div_flags[E].ovf[k] || div_quo[E][k] > fin_lim[k])
                         ? fin_lim[k] : div_quo[E][k];
            if (!div_flags[E].singular) begin
                fin_data[k*E +: E] = div_flags[E].neg[k] ? E'(-fin_mag[k]) : fin_mag[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= div_valid[E];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= fin_data;
            out_sing_reg <= div_flags[E].singular;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_sing_reg;

endmodule

// ===== rtl/minv_div_stage.sv =====
module minv_div_stage #(
    parameter int ELEM_WIDTH = 32,
    parameter int DMAG_W     = 99,
    parameter int REM_W      = 131,
    parameter int BIT_POS    = 0
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           ce,
    input  logic                                           in_valid,
    input  logic [DMAG_W-1:0]                              dmag_in,
    input  minv_pkg::minv_flags_t                          flags_in,
    input  logic [minv_pkg::LANES-1:0][REM_W-1:0]          rem_in,
    input  logic [minv_pkg::LANES-1:0][ELEM_WIDTH-1:0]     quo_in,
    output logic                                           out_valid,
    output logic [DMAG_W-1:0]                              dmag_out,
    output minv_pkg::minv_flags_t                          flags_out,
    output logic [minv_pkg::LANES-1:0][REM_W-1:0]          rem_out,
    output logic [minv_pkg::LANES-1:0][ELEM_WIDTH-1:0]     quo_out
);
    import minv_pkg::*;

    logic                                valid_reg;
    logic [DMAG_W-1:0]                   dmag_reg;
    minv_flags_t                         flags_reg;
    logic [LANES-1:0][REM_W-1:0]         rem_reg;
    logic [LANES-1:0][REM_W-1:0]         rem_next;
    logic [LANES-1:0][ELEM_WIDTH-1:0]    quo_reg;
    logic [LANES-1:0][ELEM_WIDTH-1:0]    quo_next;
    logic [LANES-1:0]                    take;
    logic [REM_W-1:0]                    dvs;

    // one restoring step per lane: bit BIT_POS of the quotient
    always_comb begin
        dvs = REM_W'(dmag_in);
        for (int k = 0; k < LANES; k++) begin
            take[k]     = (rem_in[k] >> BIT_POS) >= dvs;
            rem_next[k] = take[k] ? rem_in[k] - (dvs << BIT_POS) : rem_in[k];
            quo_next[k] = quo_in[k];
            quo_next[k][BIT_POS] = take[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dmag_reg  <= dmag_in;
            flags_reg <= flags_in;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign dmag_out  = dmag_reg;
    assign flags_out = flags_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

// ===== rtl/minv_checker.sv =====
module minv_checker #(
    parameter int TDATA_W = 288
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,
    input logic [0:0]         s_tuser,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic [0:0]         m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("singular result with nonzero elements");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind matrix_inverse_3x3_top minv_checker #(.TDATA_W(TDATA_W)) u_minv_checker (.*);

// ===== tb/matrix_inverse_3x3_top_tb.sv =====
`timescale 1ns / 1ps

module matrix_inverse_3x3_top_tb;

    import minv_pkg::*;

    localparam int EW      = ELEM_WIDTH_DEF;
    localparam int FB      = FRAC_BITS_DEF;
    localparam int TDATA_W = ((LANES * EW + 7) / 8) * 8;
    localparam int N_RAND  = 1500;
    localparam int LATENCY = EW + 8;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [255:0]  wide_t;

    typedef struct {
        logic  mode;
        elem_t m [LANES];
    } matrix_item_t;

    typedef struct {
        logic  singular;
        elem_t e [LANES];
        logic  known;
    } inverse_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata = '0;
    logic [0:0]         s_tuser = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [0:0]         m_tuser;

    inverse_t     inverse_q [$];
    matrix_item_t matrix_q  [$];
    inverse_t     fixed_q   [$];
    int           mismatches = 0;
    longint       cycles = 0;
    bit           stim_done = 1'b0;
    bit           hold_done = 1'b0;

    always #5 aclk = ~aclk;

    matrix_inverse_3x3_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    function automatic inverse_t invert_matrix(matrix_item_t it);
        inverse_t r;
        wide_t    a [LANES];
        wide_t    cof [LANES];
        wide_t    det, dmag, cmag, quo, lim;
        logic     neg;
        int       src;
        for (int k = 0; k < LANES; k++) a[k] = wide_t'(it.m[k]);
        for (int k = 0; k < LANES; k++) begin
            cof[k] = a[COF_P[k]] * a[COF_Q[k]] - a[COF_R[k]] * a[COF_S[k]];
            if (COF_NEG[k]) cof[k] = -cof[k];
        end
        det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
        r.known = 1'b0;
        r.singular = (det == 0);
        for (int k = 0; k < LANES; k++) r.e[k] = '0;
        if (r.singular) return r;
        dmag = det < 0 ? -det : det;
        for (int k = 0; k < LANES; k++) begin
            src  = it.mode ? (k % 3) * 3 + k / 3 : k;
            neg  = (cof[src] < 0) != (det < 0);
            cmag = cof[src] < 0 ? -cof[src] : cof[src];
            quo  = (cmag <<< (2 * FB)) / dmag;
            lim  = neg ? (wide_t'(1) <<< (EW - 1)) : (wide_t'(1) <<< (EW - 1)) - 1;
            if (quo > lim) quo = lim;
            if (neg) quo = -quo;
            r.e[k] = quo[EW-1:0];
        end
        return r;
    endfunction

    function automatic matrix_item_t diag_matrix(logic mode, elem_t d0, elem_t d1, elem_t d2);
        matrix_item_t it;
        it.mode = mode;
        for (int k = 0; k < LANES; k++) it.m[k] = '0;
        it.m[0] = d0;
        it.m[4] = d1;
        it.m[8] = d2;
        return it;
    endfunction

    function automatic elem_t rand_elem();
        case ($urandom_range(0, 5))
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(0, 4)) <<< 16;
            2: return -(elem_t'($urandom_range(0, 4)) <<< 16);
            3: return elem_t'($signed($urandom_range(0, 2047)) - 1024) <<< 8;
            4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return elem_t'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic matrix_item_t rand_matrix();
        matrix_item_t it;
        it.mode = 1'($urandom_range(0, 1));
        for (int k = 0; k < LANES; k++) it.m[k] = rand_elem();
        // occasionally repeat a column to force a singular matrix
        if ($urandom_range(0, 9) == 0)
            for (int r = 0; r < 3; r++) it.m[6 + r] = it.m[3 * $urandom_range(0, 1) + r];
        return it;
    endfunction

    function automatic int k_upper(int n);
        return (n * 4 + 1) % LANES;
    endfunction

    // directed table: the few rows with results typed in are marked known
    task automatic build_directed();
        matrix_item_t it;
        inverse_t     ex;
        ex.known = 1'b1;
        ex.singular = 1'b1;
        for (int k = 0; k < LANES; k++) ex.e[k] = '0;
        it = diag_matrix(1'b0, '0, '0, '0);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        it = diag_matrix(1'b1, 32'sh7fffffff, 32'sh80000000, '0);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        ex.singular = 1'b0;
        ex.e[0] = 32'sh00010000; ex.e[4] = 32'sh00010000; ex.e[8] = 32'sh00010000;
        it = diag_matrix(1'b0, 32'sh00010000, 32'sh00010000, 32'sh00010000);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        it.mode = 1'b1;
        matrix_q.push_back(it); fixed_q.push_back(ex);
        ex.e[0] = 32'sh7fffffff; ex.e[4] = 32'sh7fffffff; ex.e[8] = 32'sh7fffffff;
        it = diag_matrix(1'b0, 32'sh00000001, 32'sh00000001, 32'sh00000001);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        ex.e[0] = 32'sh80000000; ex.e[4] = 32'sh80000000; ex.e[8] = 32'sh80000000;
        it = diag_matrix(1'b1, -32'sh00000001, -32'sh00000001, -32'sh00000001);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        ex.known = 1'b0;
        it = diag_matrix(1'b0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        it = diag_matrix(1'b0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        it = diag_matrix(1'b0, 32'sh00030000, 32'sh00030000, 32'sh00030000);
        matrix_q.push_back(it); fixed_q.push_back(ex);
        for (int n = 0; n < 4; n++) begin
            it.mode = n[0];
            for (int k = 0; k < LANES; k++)
                it.m[k] = elem_t'((k * 7 + n * 3) % 11 - 5) <<< 16;
            it.m[k_upper(n)] = n[1] ? 32'sh7fffffff : 32'sh80000000;
            matrix_q.push_back(it); fixed_q.push_back(ex);
        end
        for (int n = 0; n < 4; n++) begin
            it.mode = n[0];
            for (int k = 0; k < LANES; k++) it.m[k] = n[1] ? 32'shffffffff : 32'sh55555555;
            it.m[n + 2] = 32'shaaaaaaaa;
            matrix_q.push_back(it); fixed_q.push_back(ex);
        end
    endtask

    task automatic send_matrix(matrix_item_t it, inverse_t ex);
        logic [TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < LANES; k++) d[k*EW +: EW] = it.m[k];
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= it.mode;
        do @(posedge aclk); while (!s_tready);
        if (!ex.known) begin
            ex = invert_matrix(it);
        end
        inverse_q.push_back(ex);
    endtask

    task automatic idle_gap();
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    initial begin
        matrix_item_t it;
        inverse_t     ex;
        int           burst;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        build_directed();
        ex.known = 1'b0;
        while (matrix_q.size() > 0) begin
            send_matrix(matrix_q.pop_front(), fixed_q.pop_front());
            idle_gap();
        end
        for (int n = 0; n < N_RAND; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RAND; b++, n++)
                send_matrix(rand_matrix(), ex);
            idle_gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        repeat (30) @(posedge aclk);
        m_tready <= 1'b0;
        repeat (300) @(posedge aclk);
        hold_done = 1'b1;
        forever begin
            stall = $urandom_range(0, 7);
            if (stall >= 5) begin
                m_tready <= 1'b0;
                repeat (stall - 4) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        inverse_t ex;
        logic     bad;
        if (aresetn && m_tvalid && m_tready) begin
            if (inverse_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer at cycle %0d", cycles);
            end else begin
                ex = inverse_q.pop_front();
                bad = (m_tuser[0] !== ex.singular);
                for (int k = 0; k < LANES; k++)
                    if (m_tdata[k*EW +: EW] !== ex.e[k]) bad = 1'b1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp singular %0b, got %0b", ex.singular, m_tuser[0]);
                        for (int k = 0; k < LANES; k++)
                            $display("  elem %0d exp %h got %h", k, ex.e[k],
                                     m_tdata[k*EW +: EW]);
                    end
                end
            end
        end
    end

    initial begin
        while (!(stim_done && hold_done && inverse_q.size() == 0) && cycles < CYCLE_LIMIT)
            @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (cycles >= CYCLE_LIMIT || inverse_q.size() != 0) begin
            $display("matrix_inverse_3x3_top verification failed");
        end else if (mismatches == 0) begin
            $display("matrix_inverse_3x3_top verification clean");
        end else begin
            $display("matrix_inverse_3x3_top verification failed");
        end
        $finish;
    end

    always @(posedge aclk) cycles <= cycles + 1;

endmodule

// ===== matrix_inverse_3x3_top.f =====
rtl/minv_pkg.sv
rtl/minv_div_stage.sv
rtl/matrix_inverse_3x3_top.sv
rtl/minv_checker.sv
tb/matrix_inverse_3x3_top_tb.sv
